// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== hdl/dvu_pkg.sv =====
package dvu_pkg;

   localparam int NODES     = 16;
   localparam int DIST_BITS = 16;
   localparam int CELLS     = NODES * NODES;
   localparam int CELL_BITS = $clog2(CELLS);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_INDEX_BITS = CSR_ADDR_BITS - 2;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   localparam csr_index_type REG_OWN_NODE = csr_index_type'(0);

   typedef logic [3:0]           node_type;
   typedef logic [15:0]          field_dist_type;
   typedef logic [DIST_BITS-1:0] dist_type;
   typedef logic [CELL_BITS-1:0] cell_type;

   localparam dist_type DIST_INF = '1;

   typedef struct packed {
      node_type       origin_node;
      node_type       entry_index;
      field_dist_type adv_distance;
      node_type       adv_next_hop;
      field_dist_type link_cost;
      logic           last_entry;
   } req_item_type;

   typedef struct packed {
      field_dist_type best_distance;
      node_type       best_next_hop;
      logic           entry_improved;
      logic           vector_changed;
      logic           table_changed;
      logic           vector_done;
   } rsp_item_type;

   typedef struct packed {
      dist_type distance;
      node_type next_hop;
   } route_entry_type;

   // classified entry handed from the front to the back
   typedef struct packed {
      cell_type row_cell;
      cell_type own_cell;
      logic     row_diag;
      logic     own_diag;
      logic     store_ok;
      logic     relax_ok;
      logic     report_ok;
      logic     same_row;
      logic     last;
      dist_type adv;
      dist_type cand;
      node_type adv_hop;
      node_type origin;
   } job_type;

   typedef struct packed {
      logic has_item;
      logic full;
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_EVAL  = 3'b010,
      ST_WRITE = 3'b100
   } back_state_type;

   function automatic logic node_ok(input node_type v);
      return int'(v) < NODES;
   endfunction

   function automatic cell_type cell_of(input node_type row, input node_type col);
      return cell_type'(NODES * int'(row) + int'(col));
   endfunction

   // table contents after reset: zero on the diagonal, infinity elsewhere
   function automatic route_entry_type reset_entry(input logic diag);
      route_entry_type e;
      e.distance = diag ? dist_type'(0) : DIST_INF;
      e.next_hop = '0;
      return e;
   endfunction

endpackage

// ===== hdl/distance_vector_update.sv =====
// Distance-vector table update. Each req_item is one entry of a neighbour's
// advertised vector: it is stored in the origin's row of a 16 x 16 routing table
// and then the own row (row own_node, set through the register at address 0) is
// relaxed with the advertised distance plus link cost, saturated at all ones.
// Every item gives one rsp_item; the item flagged last_entry also reports whether
// the origin row or the own row changed over the vector. Entries are queued two
// deep; the table sequencer then takes each through idle, eval and write, as the
// single write port of the table RAM takes the origin-row write and the own-row
// write in separate states after a registered read. It holds one entry at a time
// and waits in write while the output stalls. A valid bit per table cell
// stands in for the reset contents, so the block takes items right after reset.
`include "assert_macros.svh"

module distance_vector_update (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  dvu_pkg::req_item_type                 req_item,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output dvu_pkg::rsp_item_type                 rsp_item,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [dvu_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);

   dvu_pkg::node_type         own_node_ff, own_node_in;
   dvu_pkg::csr_index_type    csr_index;
   logic                      csr_write;
   dvu_pkg::job_type          front_job;
   dvu_pkg::job_type          queue_head;
   dvu_pkg::queue_status_type queue_status;
   logic                      push;
   logic                      pop;

   assign pready    = 1'b1;
   assign csr_index = paddr[dvu_pkg::CSR_ADDR_BITS-1:2];
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (csr_index == dvu_pkg::REG_OWN_NODE) ? 32'(own_node_ff) : '0;

   always_comb begin
      own_node_in = own_node_ff;
      if (csr_write && csr_index == dvu_pkg::REG_OWN_NODE) begin
         own_node_in = pwdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_node_ff <= '0;
      end else begin
         own_node_ff <= own_node_in;
      end
   end

   assign req_stall = queue_status.full;
   assign push      = req_valid && !queue_status.full;

   dvu_front u_front (
      .req_item(req_item),
      .own_node(own_node_ff),
      .job     (front_job)
   );

   dvu_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_job(front_job),
      .pop     (pop),
      .head    (queue_head),
      .status  (queue_status)
   );

   dvu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (queue_head),
      .queue_status(queue_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item)
   );

   // an improving last entry of a vector must show up in its summary
   `ASSERT_SAME_CYCLE(a_improved_in_summary, clock, reset, rsp_valid && rsp_item.vector_done && rsp_item.entry_improved, rsp_item.vector_changed)
   // an improved route is never infinite
   `ASSERT_SAME_CYCLE(a_improved_finite, clock, reset, rsp_valid && rsp_item.entry_improved, rsp_item.best_distance != dvu_pkg::field_dist_type'(dvu_pkg::DIST_INF))
   // change flags only ride on the summary result
   `ASSERT_SAME_CYCLE(a_flags_on_summary, clock, reset, rsp_valid && (rsp_item.vector_changed || rsp_item.table_changed), rsp_item.vector_done)
   // a register write lands in the own node register
   `ASSERT_NEXT_CYCLE(a_own_node_write, clock, reset, csr_write && csr_index == dvu_pkg::REG_OWN_NODE, own_node_ff == $past(pwdata[3:0]))

endmodule

// ===== hdl/dvu_ram.sv =====
module dvu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ===== hdl/dvu_front.sv =====
module dvu_front (
   input  dvu_pkg::req_item_type req_item,
   input  dvu_pkg::node_type     own_node,
   output dvu_pkg::job_type      job
);

   logic                     origin_ok;
   logic                     dest_ok;
   logic                     own_ok;
   dvu_pkg::dist_type        adv;
   dvu_pkg::dist_type        cost;
   logic [dvu_pkg::DIST_BITS:0] sum;

   assign origin_ok = dvu_pkg::node_ok(req_item.origin_node);
   assign dest_ok   = dvu_pkg::node_ok(req_item.entry_index);
   assign own_ok    = dvu_pkg::node_ok(own_node);

   assign adv  = dvu_pkg::dist_type'(req_item.adv_distance);
   assign cost = dvu_pkg::dist_type'(req_item.link_cost);
   assign sum  = {1'b0, adv} + {1'b0, cost};

   always_comb begin
      job.row_cell  = dvu_pkg::cell_of(req_item.origin_node, req_item.entry_index);
      job.own_cell  = dvu_pkg::cell_of(own_node, req_item.entry_index);
      job.row_diag  = req_item.origin_node == req_item.entry_index;
      job.own_diag  = own_node == req_item.entry_index;
      job.store_ok  = origin_ok && dest_ok;
      job.relax_ok  = origin_ok && dest_ok && own_ok;
      job.report_ok = own_ok && dest_ok;
      // own row gets overwritten first when the vector comes from ourselves
      job.same_row  = origin_ok && dest_ok && (req_item.origin_node == own_node);
      job.last      = req_item.last_entry;
      job.adv       = adv;
      // saturate at infinity
      job.cand      = (sum >= {1'b0, dvu_pkg::DIST_INF}) ? dvu_pkg::DIST_INF
                                                          : sum[dvu_pkg::DIST_BITS-1:0];
      job.adv_hop   = req_item.adv_next_hop;
      job.origin    = req_item.origin_node;
   end

endmodule

// ===== hdl/dvu_queue.sv =====
module dvu_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  dvu_pkg::job_type          push_job,
   input  logic                      pop,
   output dvu_pkg::job_type          head,
   output dvu_pkg::queue_status_type status
);

   dvu_pkg::job_type               slot_ff [dvu_pkg::QUEUE_DEPTH];
   logic [dvu_pkg::QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [dvu_pkg::QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [dvu_pkg::QCNT_BITS-1:0]  count_ff, count_in;

   function automatic logic [dvu_pkg::QPTR_BITS-1:0] next_ptr(
      input logic [dvu_pkg::QPTR_BITS-1:0] p);
      return (int'(p) == dvu_pkg::QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
   endfunction

   assign head            = slot_ff[rd_ptr_ff];
   assign status.has_item = count_ff != '0;
   assign status.full     = int'(count_ff) == dvu_pkg::QUEUE_DEPTH;

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== hdl/dvu_back.sv =====
module dvu_back (
   input  logic                      clock,
   input  logic                      reset,
   input  dvu_pkg::job_type          head,
   input  dvu_pkg::queue_status_type queue_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output dvu_pkg::rsp_item_type     rsp_item
);

   dvu_pkg::back_state_type  state_ff, state_in;
   dvu_pkg::job_type         job_ff, job_in;
   logic [dvu_pkg::CELLS-1:0] valid_ff, valid_in;
   logic                     row_valid_ff, row_valid_in;
   logic                     own_valid_ff, own_valid_in;
   logic                     row_dirty_ff, row_dirty_in;
   logic                     own_dirty_ff, own_dirty_in;
   logic                     improved_ff, improved_in;
   dvu_pkg::route_entry_type own_wr_ff, own_wr_in;
   dvu_pkg::rsp_item_type    result_ff, result_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   dvu_pkg::rsp_item_type    rsp_item_ff, rsp_item_in;

   logic                     wr_en;
   dvu_pkg::cell_type        wr_addr;
   dvu_pkg::route_entry_type wr_data;
   dvu_pkg::route_entry_type rd_row;
   dvu_pkg::route_entry_type rd_own;

   dvu_pkg::route_entry_type row_old;
   dvu_pkg::route_entry_type own_old;
   dvu_pkg::route_entry_type new_entry;
   dvu_pkg::route_entry_type own_base;
   dvu_pkg::route_entry_type best;
   logic                     row_diff;
   logic                     improved;
   logic                     row_next;
   logic                     own_next;

   dvu_ram #(
      .WIDTH($bits(dvu_pkg::route_entry_type)),
      .DEPTH(dvu_pkg::CELLS)
   ) u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr_a(head.row_cell),
      .rd_data_a(rd_row),
      .rd_addr_b(head.own_cell),
      .rd_data_b(rd_own)
   );

   // evaluation of the entry latched in job_ff against the table read
   always_comb begin
      row_old  = row_valid_ff ? rd_row : dvu_pkg::reset_entry(job_ff.row_diag);
      own_old  = own_valid_ff ? rd_own : dvu_pkg::reset_entry(job_ff.own_diag);
      new_entry.distance = job_ff.adv;
      new_entry.next_hop = job_ff.adv_hop;
      row_diff = job_ff.store_ok && (row_old != new_entry);
      own_base = job_ff.same_row ? new_entry : own_old;
      improved = job_ff.relax_ok && (job_ff.cand < own_base.distance);
      if (improved) begin
         best.distance = job_ff.cand;
         best.next_hop = job_ff.origin;
      end else begin
         best = own_base;
      end
      row_next = row_dirty_ff || row_diff;
      own_next = own_dirty_ff || improved;
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      row_valid_in = row_valid_ff;
      own_valid_in = own_valid_ff;
      row_dirty_in = row_dirty_ff;
      own_dirty_in = own_dirty_ff;
      improved_in  = improved_ff;
      own_wr_in    = own_wr_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = job_ff.row_cell;
      wr_data      = new_entry;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         dvu_pkg::ST_IDLE: begin
            if (queue_status.has_item) begin
               pop          = 1'b1;
               job_in       = head;
               row_valid_in = valid_ff[head.row_cell];
               own_valid_in = valid_ff[head.own_cell];
               state_in     = dvu_pkg::ST_EVAL;
            end
         end
         dvu_pkg::ST_EVAL: begin
            wr_en        = job_ff.store_ok;
            improved_in  = improved;
            own_wr_in.distance = job_ff.cand;
            own_wr_in.next_hop = job_ff.origin;
            result_in.best_distance  = dvu_pkg::field_dist_type'(
               job_ff.report_ok ? best.distance : dvu_pkg::DIST_INF);
            result_in.best_next_hop  = job_ff.report_ok ? best.next_hop : '0;
            result_in.entry_improved = improved;
            result_in.vector_changed = job_ff.last && own_next;
            result_in.table_changed  = job_ff.last && row_next;
            result_in.vector_done    = job_ff.last;
            row_dirty_in = job_ff.last ? 1'b0 : row_next;
            own_dirty_in = job_ff.last ? 1'b0 : own_next;
            state_in     = dvu_pkg::ST_WRITE;
         end
         dvu_pkg::ST_WRITE: begin
            // rewriting the same value while the output waits is harmless
            wr_en   = improved_ff;
            wr_addr = job_ff.own_cell;
            wr_data = own_wr_ff;
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = result_ff;
               state_in     = dvu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dvu_pkg::ST_IDLE;
         end
      endcase

      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dvu_pkg::ST_IDLE;
         valid_ff     <= '0;
         row_dirty_ff <= 1'b0;
         own_dirty_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         row_dirty_ff <= row_dirty_in;
         own_dirty_ff <= own_dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      row_valid_ff <= row_valid_in;
      own_valid_ff <= own_valid_in;
      improved_ff  <= improved_in;
      own_wr_ff    <= own_wr_in;
      result_ff    <= result_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== sim/distance_vector_update_check.sv =====
module distance_vector_update_check (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  dvu_pkg::req_item_type             req_item,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  dvu_pkg::rsp_item_type             rsp_item,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic                              pready,
   input  logic [dvu_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]                       pwdata,
   input  logic [31:0]                       prdata,
   output int                                mismatches,
   output int                                routes_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import dvu_pkg::*;

   dist_type     dist_table [CELLS];
   node_type     hop_table [CELLS];
   node_type     own_node;
   logic         origin_row_dirty;
   logic         own_row_dirty;
   rsp_item_type expected_routes [$];
   int           mismatch_count = 0;
   int           pending_count = 0;

   assign mismatches     = mismatch_count;
   assign routes_pending = pending_count;

   // node fields are 4 bits and the table is 16 x 16, so every index is in range
   function automatic rsp_item_type relax_route(input req_item_type it);
      rsp_item_type       r;
      int                 row_cell;
      int                 own_cell;
      logic [DIST_BITS:0] sum;
      dist_type           cand;
      row_cell = int'(it.origin_node) * NODES + int'(it.entry_index);
      own_cell = int'(own_node) * NODES + int'(it.entry_index);
      if (dist_table[row_cell] != it.adv_distance || hop_table[row_cell] != it.adv_next_hop) begin
         dist_table[row_cell] = it.adv_distance;
         hop_table[row_cell]  = it.adv_next_hop;
         origin_row_dirty     = 1'b1;
      end
      // the origin row is written first, so an origin equal to own_node relaxes
      // against the value it just stored
      sum  = {1'b0, it.adv_distance} + {1'b0, it.link_cost};
      cand = (sum >= {1'b0, DIST_INF}) ? DIST_INF : sum[DIST_BITS-1:0];
      r = '0;
      if (cand < dist_table[own_cell]) begin
         dist_table[own_cell] = cand;
         hop_table[own_cell]  = it.origin_node;
         own_row_dirty        = 1'b1;
         r.entry_improved     = 1'b1;
      end
      r.best_distance  = dist_table[own_cell];
      r.best_next_hop  = hop_table[own_cell];
      r.vector_changed = it.last_entry && own_row_dirty;
      r.table_changed  = it.last_entry && origin_row_dirty;
      r.vector_done    = it.last_entry;
      if (it.last_entry) begin
         own_row_dirty    = 1'b0;
         origin_row_dirty = 1'b0;
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         for (int c = 0; c < CELLS; c++) begin
            dist_table[c] = (c / NODES == c % NODES) ? dist_type'(0) : DIST_INF;
            hop_table[c]  = '0;
         end
         own_node         = '0;
         origin_row_dirty = 1'b0;
         own_row_dirty    = 1'b0;
         expected_routes.delete();
      end else begin
         if (psel && penable && pready && paddr[CSR_ADDR_BITS-1:2] == REG_OWN_NODE) begin
            if (pwrite)
               own_node = pwdata[3:0];
            else
               check_field("own_node", 32'(own_node), prdata);
         end
         if (req_valid && !req_stall)
            expected_routes.push_back(relax_route(req_item));
         if (rsp_valid && !rsp_stall) begin
            if (expected_routes.size() == 0) begin
               $error("result with no item waiting: %p", rsp_item);
               mismatch_count++;
            end else begin
               want = expected_routes.pop_front();
               check_field("best_distance", want.best_distance, rsp_item.best_distance);
               check_field("best_next_hop", want.best_next_hop, rsp_item.best_next_hop);
               check_field("entry_improved", want.entry_improved, rsp_item.entry_improved);
               check_field("vector_changed", want.vector_changed, rsp_item.vector_changed);
               check_field("table_changed", want.table_changed, rsp_item.table_changed);
               check_field("vector_done", want.vector_done, rsp_item.vector_done);
            end
         end
      end
      pending_count = expected_routes.size();
   end

endmodule

// ===== sim/distance_vector_update_test.sv =====
module distance_vector_update_test;
   timeunit 1ns;
   timeprecision 1ps;
   import dvu_pkg::*;

   typedef enum logic [1:0] {
      PACE_STEADY,
      PACE_SENDER_GAPS,
      PACE_RECEIVER_STALLS,
      PACE_BOTH
   } pace_type;

   localparam int PHASE_ITEMS = 205;
   localparam int HOLD_CYCLES = 120;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_item_type             req_item = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_item_type             rsp_item;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [31:0]              pwdata = '0;
   logic [31:0]              prdata;
   logic                     pready;

   int          mismatches;
   int          routes_pending;
   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned hold_asked = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;

   distance_vector_update dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   distance_vector_update_check check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item       (rsp_item),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .mismatches     (mismatches),
      .routes_pending (routes_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("distance_vector_update_test NOT OK");
      $finish;
   end

   // receiver: random stalls, or a long hold-off when one is asked for
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_served != hold_asked) begin
         hold_served++;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_entry(input req_item_type e);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= e;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_fields(input node_type o, input node_type idx, input field_dist_type d,
                              input node_type h, input field_dist_type c, input logic l);
      req_item_type e;
      e.origin_node  = o;
      e.entry_index  = idx;
      e.adv_distance = d;
      e.adv_next_hop = h;
      e.link_cost    = c;
      e.last_entry   = l;
      send_entry(e);
   endtask

   task automatic csr_access(input logic wr, input csr_index_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic field_dist_type pick_distance();
      case ($urandom_range(7))
         0:       return '1;
         1:       return 16'hFFFF - 16'($urandom_range(15));
         2:       return 16'($urandom);
         default: return 16'($urandom_range(300));
      endcase
   endfunction

   function automatic field_dist_type pick_cost();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return 16'($urandom);
         default: return 16'($urandom_range(1, 40));
      endcase
   endfunction

   initial begin
      req_item_type vec [$];
      req_item_type prev [$];
      req_item_type e;
      node_type     own;
      node_type     org;
      node_type     plan_own [8];
      pace_type     pace;
      field_dist_type cost;
      int           span;
      int           sent;
      int           drain;

      plan_own = '{4'd15, 4'd0, 4'd7, 4'd15, 4'd3, 4'd0, 4'd0, 4'd9};
      plan_own[6] = node_type'($urandom_range(15));
      own = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value of own_node, then directed entries against row 0
      csr_access(1'b0, REG_OWN_NODE, '0);
      send_fields(4'd1, 4'd2, 16'd10, 4'd3, 16'd5, 1'b0);
      send_fields(4'd1, 4'd2, 16'd10, 4'd3, 16'd5, 1'b1);
      send_fields(4'd1, 4'd2, 16'd10, 4'd3, 16'd5, 1'b1);
      send_fields(4'd2, 4'd2, 16'd0, 4'd9, 16'd0, 1'b1);
      // saturation and a link that is down
      send_fields(4'd3, 4'd5, 16'hFFFE, 4'd1, 16'd1, 1'b0);
      send_fields(4'd3, 4'd6, 16'hFFFF, 4'd2, 16'hFFFF, 1'b0);
      send_fields(4'd3, 4'd7, 16'hFFFD, 4'd4, 16'd1, 1'b1);
      send_fields(4'd3, 4'd8, 16'd0, 4'd5, 16'hFFFF, 1'b1);
      // origin is the own node: own row is overwritten before relaxing
      send_fields(4'd0, 4'd4, 16'd100, 4'd7, 16'd3, 1'b0);
      send_fields(4'd0, 4'd0, 16'hFFFF, 4'd6, 16'd0, 1'b0);
      send_fields(4'd4, 4'd0, 16'd0, 4'd0, 16'd0, 1'b1);
      send_fields(4'd15, 4'd15, 16'hFFFF, 4'd15, 16'hFFFF, 1'b1);
      send_fields(4'd0, 4'd0, 16'd0, 4'd0, 16'd0, 1'b0);
      send_fields(4'd5, 4'd9, 16'hAAAA, 4'd10, 16'h5555, 1'b0);
      send_fields(4'd6, 4'd9, 16'h5555, 4'd5, 16'hAAAA, 1'b1);
      send_fields(4'd6, 4'd9, 16'h5555, 4'd5, 16'hAAA9, 1'b1);
      req_valid <= 1'b0;

      for (int p = 0; p < 8; p++) begin
         while (routes_pending != 0) @(posedge clock);
         repeat (8) @(posedge clock);
         own = plan_own[p];
         csr_access(1'b1, REG_OWN_NODE, 32'(own));
         csr_access(1'b0, REG_OWN_NODE, '0);

         pace = pace_type'(p % 4);
         case (pace)
            PACE_STEADY:          begin gap_pct = 0;  stall_pct = 0;  end
            PACE_SENDER_GAPS:     begin gap_pct = 57; stall_pct = 0;  end
            PACE_RECEIVER_STALLS: begin gap_pct = 0;  stall_pct = 57; end
            default:              begin gap_pct = 6;  stall_pct = 6;  end
         endcase
         // the block fills up while the receiver holds off
         if (p == 0) hold_asked++;

         sent = 0;
         prev.delete();
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(9) == 0) begin
               vec.delete();
               e = req_item_type'({$urandom, $urandom});
               vec.push_back(e);
            end else if (prev.size() != 0 && $urandom_range(3) == 0) begin
               // a repeated vector sends the previous vector again
               vec = prev;
            end else begin
               vec.delete();
               org  = ($urandom_range(4) == 0) ? own : node_type'($urandom_range(15));
               cost = pick_cost();
               span = $urandom_range(1) ? 16 : $urandom_range(1, 16);
               for (int k = 0; k < span; k++) begin
                  e.origin_node  = org;
                  e.entry_index  = (span == 16) ? node_type'(k) : node_type'($urandom_range(15));
                  e.adv_distance = pick_distance();
                  e.adv_next_hop = node_type'($urandom_range(15));
                  e.link_cost    = cost;
                  e.last_entry   = (k == span - 1);
                  vec.push_back(e);
               end
               // now and then a vector loses its last flag and runs into the next
               if ($urandom_range(9) == 0) vec[vec.size()-1].last_entry = 1'b0;
               prev = vec;
            end
            foreach (vec[k]) begin
               send_entry(vec[k]);
               sent++;
            end
         end
         req_valid <= 1'b0;
      end

      drain = 0;
      while (routes_pending != 0 && drain < 50000) begin
         @(posedge clock);
         drain++;
      end
      repeat (20) @(posedge clock);
      if (routes_pending != 0) $error("%0d results never arrived", routes_pending);
      if (mismatches == 0 && routes_pending == 0) begin
         $display("distance_vector_update_test OK");
      end else begin
         $display("distance_vector_update_test NOT OK");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/dvu_pkg.sv
hdl/dvu_ram.sv
hdl/dvu_front.sv
hdl/dvu_queue.sv
hdl/dvu_back.sv
hdl/distance_vector_update.sv
sim/distance_vector_update_check.sv
sim/distance_vector_update_test.sv
